// ----- hw/rtl/satag_pkg.sv -----
// Package for the set-associative tag store: sizes, widths and shared types.
// Used by every module of the block but satag_ram; no dependencies.
package satag_pkg;
	localparam int SETS_DEF = 64;
	localparam int WAYS_DEF = 8;
	localparam int TAG_BITS_DEF = 40;
	localparam int STAMP_BITS_DEF = 48;
	localparam int SET_W = 6;
	localparam int TAG_W = 40;
	localparam int CNT_W = 4;
	localparam int FILL_W = 10;
	localparam logic [FILL_W-1:0] FILL_MAX = 10'd1023;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_EVAL
	} bk_state_t;

	typedef struct packed {
		logic [SET_W-1:0] set_index;
		logic [TAG_W-1:0] line_tag;
	} req_t;

	typedef struct packed {
		logic                hit;
		logic [CNT_W-1:0]    recency_position;
		logic [CNT_W-1:0]    valid_ways;
		logic                evicted_valid;
		logic [FILL_W-1:0]   total_fills;
	} rsp_t;
endpackage

// ----- hw/rtl/satag_if.sv -----
// Valid/ready channel interfaces for the tag store.
// Depends on satag_pkg.
interface satag_req_if;
	import satag_pkg::*;
	logic valid;
	logic ready;
	logic [SET_W-1:0] set_index;
	logic [TAG_W-1:0] line_tag;
	modport source (output valid, set_index, line_tag, input ready);
	modport sink (input valid, set_index, line_tag, output ready);
endinterface

interface satag_rsp_if;
	import satag_pkg::*;
	logic valid;
	logic ready;
	logic hit;
	logic [CNT_W-1:0] recency_position;
	logic [CNT_W-1:0] valid_ways;
	logic evicted_valid;
	logic [FILL_W-1:0] total_fills;
	modport source (output valid, hit, recency_position, valid_ways, evicted_valid,
		total_fills, input ready);
	modport sink (input valid, hit, recency_position, valid_ways, evicted_valid,
		total_fills, output ready);
endinterface

interface satag_cfg_if;
	logic valid;
	logic ready;
	logic data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- hw/rtl/satag_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module satag_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ----- hw/rtl/satag_front.sv -----
// Front end: accepts access beats, folds the set index into range, masks the
// tag to TAG_BITS and queues them in a two-entry FIFO. Depends on satag_pkg.
module satag_front
	import satag_pkg::*;
#(
	parameter int SETS = SETS_DEF,
	parameter int TAG_BITS = TAG_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	satag_req_if.sink in,
	output logic  q_valid,
	input  logic  q_pop,
	output req_t  q_head
);
	req_t        mem_q [2];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;
	req_t        nw;
	logic        push;

	assign in.ready = (cnt_q != 2'd2);
	assign push = in.valid && in.ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_head = mem_q[rp_q];

	always_comb begin
		nw.set_index = SET_W'(32'(in.set_index) % SETS);
		nw.line_tag = in.line_tag & TAG_W'({TAG_BITS{1'b1}});
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= nw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule

// ----- hw/rtl/satag_back.sv -----
// Back end: reads a whole set, compares all ways, picks the way and writes
// tag, stamp and tree bits back. Depends on satag_pkg and satag_ram.
module satag_back
	import satag_pkg::*;
#(
	parameter int SETS = SETS_DEF,
	parameter int WAYS = WAYS_DEF,
	parameter int TAG_BITS = TAG_BITS_DEF,
	parameter int STAMP_BITS = STAMP_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic plru_mode,
	input  logic q_valid,
	output logic q_pop,
	input  req_t q_head,
	satag_rsp_if.source out
);
	localparam int SA_W = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WI_W = $clog2(WAYS);
	localparam int NODES = WAYS - 1;
	localparam int LEVELS = $clog2(WAYS);
	localparam int ENTRY_W = 1 + TAG_BITS + STAMP_BITS;

	bk_state_t state_q, state_d;
	logic [SA_W-1:0] clr_q;
	logic [SA_W-1:0] set_s1;
	logic [TAG_BITS-1:0] tag_s1;
	logic [STAMP_BITS-1:0] ctr_q;
	logic [FILL_W-1:0] fill_q;
	logic out_v_q;
	rsp_t out_q;

	logic [SA_W-1:0] addr;
	logic we;
	logic [ENTRY_W-1:0] wdat [WAYS];
	logic [ENTRY_W-1:0] rdat [WAYS];
	logic [NODES-1:0] tr_wdat, tr_rdat;
	logic [NODES-1:0] tr_new;

	logic [WAYS-1:0] vld, hitv;
	logic [TAG_BITS-1:0] tg [WAYS];
	logic [STAMP_BITS-1:0] st [WAYS];
	logic hit;
	logic [WI_W-1:0] hit_way, free_way, lru_way, tree_way, way;
	logic has_free;
	logic [CNT_W-1:0] nvalid, pos;
	logic [STAMP_BITS-1:0] ts;
	logic [STAMP_BITS-1:0] ctr_n;

	for (genvar g = 0; g < WAYS; g++) begin : g_way
		satag_ram #(.WIDTH(ENTRY_W), .DEPTH(SETS)) u_ram (
			.clk, .we, .addr, .wdata(wdat[g]), .rdata(rdat[g]));
		assign vld[g] = rdat[g][ENTRY_W-1] && (state_q == ST_EVAL);
		assign tg[g] = rdat[g][TAG_BITS+STAMP_BITS-1:STAMP_BITS];
		assign st[g] = rdat[g][STAMP_BITS-1:0];
		assign hitv[g] = vld[g] && (tg[g] == tag_s1);
		assign wdat[g] = (state_q == ST_CLEAR) ? '0 :
			(way == WI_W'(g)) ? {1'b1, tag_s1, ctr_n} : rdat[g];
	end
	satag_ram #(.WIDTH(NODES), .DEPTH(SETS)) u_tree (
		.clk, .we, .addr, .wdata(tr_wdat), .rdata(tr_rdat));

	assign ctr_n = ctr_q + 1'b1;

	always_comb begin
		hit_way = '0; hit = 1'b0; free_way = '0; has_free = 1'b0;
		nvalid = '0; lru_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (hitv[w]) begin hit = 1'b1; hit_way = WI_W'(w); end
			if (!vld[w]) begin has_free = 1'b1; free_way = WI_W'(w); end
		end
		for (int w = 0; w < WAYS; w++) begin
			nvalid = nvalid + CNT_W'(vld[w]);
			if (st[w] < st[lru_way]) lru_way = WI_W'(w);
		end
		ts = st[hit_way];
		pos = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (vld[w] && st[w] > ts) pos = pos + 1'b1;
		end
		if (!hit) pos = CNT_W'(WAYS);
	end

	// Tree walk and touch over log2(WAYS) levels.
	always_comb begin
		int node, low, span, half, dir;
		node = 0; span = WAYS; tree_way = '0;
		for (int l = 0; l < LEVELS; l++) begin
			dir = (node < NODES) ? int'(tr_rdat[node]) : 0;
			tree_way = WI_W'(tree_way * 2 + dir);
			node = node * 2 + 1 + dir;
			span = span / 2;
		end
		way = hit ? hit_way : has_free ? free_way : plru_mode ? tree_way : lru_way;
		tr_new = tr_rdat;
		node = 0; low = 0; span = WAYS;
		for (int l = 0; l < LEVELS; l++) begin
			half = span / 2;
			dir = (int'(way) < low + half) ? 0 : 1;
			if (node < NODES) tr_new[node] = (dir == 0);
			node = node * 2 + 1 + dir;
			if (dir != 0) low = low + half;
			span = half;
		end
		tr_wdat = (state_q == ST_CLEAR) ? '0 : plru_mode ? tr_new : tr_rdat;
	end

	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		we = 1'b0;
		addr = set_s1;
		case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
				addr = clr_q;
				if (32'(clr_q) == SETS - 1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (q_valid && (!out_v_q || out.ready)) begin
					q_pop = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_EVAL;
			ST_EVAL: begin
				we = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			ctr_q <= '0;
			fill_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (out_v_q && out.ready) out_v_q <= 1'b0;
			if (state_q == ST_EVAL) begin
				ctr_q <= ctr_n;
				out_v_q <= 1'b1;
				if (!hit && has_free && fill_q != FILL_MAX) fill_q <= fill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			set_s1 <= SA_W'(q_head.set_index);
			tag_s1 <= TAG_BITS'(q_head.line_tag);
		end
		if (state_q == ST_EVAL) begin
			out_q.hit <= hit;
			out_q.recency_position <= pos;
			out_q.valid_ways <= nvalid;
			out_q.evicted_valid <= !hit && !has_free;
			out_q.total_fills <= (!hit && has_free && fill_q != FILL_MAX) ?
				fill_q + 1'b1 : fill_q;
		end
	end

	assign out.valid = out_v_q;
	assign out.hit = out_q.hit;
	assign out.recency_position = out_q.recency_position;
	assign out.valid_ways = out_q.valid_ways;
	assign out.evicted_valid = out_q.evicted_valid;
	assign out.total_fills = out_q.total_fills;
endmodule

// ----- hw/rtl/set_assoc_tag_store_lru_plru_top.sv -----
// Set-associative tag store with true-LRU or tree-PLRU replacement.
// An accepted beat passes the two-entry queue and the idle, read and evaluate
// states, and its result beat is registered and held until it is taken.
// The back end takes a new access only once it is through with the last, as
// each runs the read-evaluate-write sequence on the single-port set memories.
// Reset: asynchronous, active low; then a clearing pass over all SETS sets
// empties them, during which accesses queue but are not processed.
module set_assoc_tag_store_lru_plru_top
	import satag_pkg::*;
#(
	parameter int SETS = SETS_DEF,
	parameter int WAYS = WAYS_DEF,
	parameter int TAG_BITS = TAG_BITS_DEF,
	parameter int STAMP_BITS = STAMP_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	satag_cfg_if.sink cfg,
	satag_req_if.sink in,
	satag_rsp_if.source out
);
	logic plru_mode_q;
	logic q_valid, q_pop;
	req_t q_head;

	// The mode register takes a write beat at any time.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plru_mode_q <= 1'b0;
		end else if (cfg.valid) begin
			plru_mode_q <= cfg.data;
		end
	end

	// The front end queues access beats so the back end can stall alone.
	satag_front #(.SETS(SETS), .TAG_BITS(TAG_BITS)) u_front (
		.clk, .arst_n, .in, .q_valid, .q_pop, .q_head);

	// The back end runs each access against the set memories.
	satag_back #(.SETS(SETS), .WAYS(WAYS), .TAG_BITS(TAG_BITS),
		.STAMP_BITS(STAMP_BITS)) u_back (
		.clk, .arst_n, .plru_mode(plru_mode_q), .q_valid, .q_pop, .q_head, .out);
endmodule

// ----- hw/rtl/satag_chk.sv -----
// Port checker for the tag store, bound to the top level.
// Depends on satag_pkg.
module satag_chk
	import satag_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic hit,
	input logic [CNT_W-1:0] recency_position,
	input logic [CNT_W-1:0] valid_ways,
	input logic evicted_valid,
	input logic [FILL_W-1:0] total_fills
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(total_fills))
		else $error("result dropped while stalled");
	a_hit_ev: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && evicted_valid))
		else $error("hit with eviction");
	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> recency_position < valid_ways)
		else $error("recency position out of range");
	a_ev: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && evicted_valid |-> valid_ways == CNT_W'(WAYS_DEF))
		else $error("eviction in a set not full");
endmodule

bind set_assoc_tag_store_lru_plru_top satag_chk u_chk (
	.clk, .arst_n, .out_valid(out.valid), .out_ready(out.ready), .hit(out.hit),
	.recency_position(out.recency_position), .valid_ways(out.valid_ways),
	.evicted_valid(out.evicted_valid), .total_fills(out.total_fills));
